/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks a condition in the same cycle, outside reset
`define DRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drc assertion failed");

// checks a condition in the next cycle, outside reset
`define DRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drc assertion failed");

// checks a condition in the next cycle, reset included
`define DRC_ASSERT_ALWAYS_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("drc assertion failed");

`endif

/* sv/drc_pkg.sv */
package drc_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] in_x;
    logic signed [15:0] in_y;
    logic        [15:0] in_width;
    logic        [15:0] in_height;
  } request_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic        [15:0] out_width;
    logic        [15:0] out_height;
    logic               is_last;
    logic               is_empty;
    logic               overflowed;
  } result_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [15:0] w;
    logic        [15:0] h;
  } rect_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_COMPARE,
    ST_MERGE,
    ST_APPEND,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic wr_merge;
    logic wr_append;
    logic emit;
    logic emit_last;
    logic emit_empty;
    logic emit_ovf;
  } ctrl_t;

endpackage

/* sv/drc_datapath.sv */
module drc_datapath #(
  parameter int MAX_REGIONS = 16,
  parameter int AW          = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  drc_pkg::ctrl_t     ctrl,
  input  logic [AW-1:0]      addr,
  input  drc_pkg::request_t  request,
  output logic               touch,
  output logic               strobe,
  output drc_pkg::result_t   result
);

  drc_pkg::rect_t mem [MAX_REGIONS];
  drc_pkg::rect_t in_r;
  drc_pkg::rect_t rd;
  drc_pkg::rect_t merged;
  drc_pkg::rect_t merged_next;
  logic last_r;
  logic empty_r;
  logic ovf_r;

  logic signed [17:0] r_x0, r_y0, r_x1, r_y1;
  logic signed [17:0] i_x0, i_y0, i_x1, i_y1;

  function automatic logic [31:0] span_merge(input logic signed [17:0] a0,
                                             input logic signed [17:0] a1,
                                             input logic signed [17:0] b0,
                                             input logic signed [17:0] b1);
    logic signed [17:0] lo;
    logic signed [17:0] hi;
    logic signed [18:0] d;
    logic [15:0] len;
    lo = (a0 < b0) ? a0 : b0;
    hi = (a1 > b1) ? a1 : b1;
    d = 19'(hi) - 19'(lo);
    len = (d > 19'sd65535) ? 16'hffff : d[15:0];
    return {lo[15:0], len};
  endfunction

  always_comb begin
    r_x0 = 18'(rd.x);
    r_y0 = 18'(rd.y);
    r_x1 = r_x0 + $signed({2'b00, rd.w});
    r_y1 = r_y0 + $signed({2'b00, rd.h});
    i_x0 = 18'(in_r.x);
    i_y0 = 18'(in_r.y);
    i_x1 = i_x0 + $signed({2'b00, in_r.w});
    i_y1 = i_y0 + $signed({2'b00, in_r.h});
    touch = !(r_x1 < i_x0 || i_x1 < r_x0 || r_y1 < i_y0 || i_y1 < r_y0);
    {merged_next.x, merged_next.w} = span_merge(r_x0, r_x1, i_x0, i_x1);
    {merged_next.y, merged_next.h} = span_merge(r_y0, r_y1, i_y0, i_y1);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_in) begin
      in_r <= '{x: request.in_x, y: request.in_y, w: request.in_width,
                h: request.in_height};
    end
    merged <= merged_next;
    if (ctrl.rd_en) begin
      rd <= mem[addr];
    end
    if (ctrl.wr_merge) begin
      mem[addr] <= merged;
    end else if (ctrl.wr_append) begin
      mem[addr] <= in_r;
    end
    last_r  <= ctrl.emit_last;
    empty_r <= ctrl.emit_empty;
    ovf_r   <= ctrl.emit_ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctrl.emit;
    end
  end

  always_comb begin
    result.out_x      = empty_r ? '0 : rd.x;
    result.out_y      = empty_r ? '0 : rd.y;
    result.out_width  = empty_r ? '0 : rd.w;
    result.out_height = empty_r ? '0 : rd.h;
    result.is_last    = last_r;
    result.is_empty   = empty_r;
    result.overflowed = ovf_r;
  end

endmodule

/* sv/drc_control.sv */
module drc_control #(
  parameter int MAX_REGIONS = 16,
  parameter int AW          = 4,
  parameter int CW          = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            cmd,
  input  logic            touch,
  output logic            busy,
  output drc_pkg::ctrl_t  ctrl,
  output logic [AW-1:0]   addr
);

  drc_pkg::state_t state, state_next;
  logic [AW-1:0] idx, idx_next;
  logic [CW-1:0] count, count_next;
  logic overflow, overflow_next;
  logic at_last;
  logic full;

  assign at_last = (CW'(idx) + CW'(1)) == count;
  assign full    = count == CW'(MAX_REGIONS);
  assign busy    = state != drc_pkg::ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= drc_pkg::ST_IDLE;
      idx      <= '0;
      count    <= '0;
      overflow <= 1'b0;
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    count_next    = count;
    overflow_next = overflow;
    ctrl          = '0;
    addr          = idx;
    unique case (state)
      drc_pkg::ST_IDLE: begin
        if (start) begin
          ctrl.load_in = 1'b1;
          idx_next     = '0;
          if (cmd == drc_pkg::CMD_FLUSH) begin
            if (count == '0) begin
              ctrl.emit       = 1'b1;
              ctrl.emit_last  = 1'b1;
              ctrl.emit_empty = 1'b1;
              ctrl.emit_ovf   = overflow;
              overflow_next   = 1'b0;
            end else begin
              state_next = drc_pkg::ST_FLUSH;
            end
          end else if (count == '0) begin
            state_next = drc_pkg::ST_APPEND;
          end else begin
            state_next = drc_pkg::ST_READ;
          end
        end
      end
      drc_pkg::ST_READ: begin
        ctrl.rd_en = 1'b1;
        state_next = drc_pkg::ST_COMPARE;
      end
      drc_pkg::ST_COMPARE: begin
        priority if (touch) begin
          state_next = drc_pkg::ST_MERGE;
        end else if (at_last && full) begin
          overflow_next = 1'b1;
          state_next    = drc_pkg::ST_MERGE;
        end else if (at_last) begin
          state_next = drc_pkg::ST_APPEND;
        end else begin
          idx_next   = idx + AW'(1);
          state_next = drc_pkg::ST_READ;
        end
      end
      drc_pkg::ST_MERGE: begin
        ctrl.wr_merge = 1'b1;
        state_next    = drc_pkg::ST_IDLE;
      end
      drc_pkg::ST_APPEND: begin
        ctrl.wr_append = 1'b1;
        addr           = count[AW-1:0];
        count_next     = count + CW'(1);
        state_next     = drc_pkg::ST_IDLE;
      end
      drc_pkg::ST_FLUSH: begin
        ctrl.rd_en     = 1'b1;
        ctrl.emit      = 1'b1;
        ctrl.emit_last = at_last;
        ctrl.emit_ovf  = overflow;
        if (at_last) begin
          count_next    = '0;
          overflow_next = 1'b0;
          state_next    = drc_pkg::ST_IDLE;
        end else begin
          idx_next = idx + AW'(1);
        end
      end
      default: begin
        state_next = drc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/dirty_region_coalescer_core.sv */
// dirty rectangle coalescer
// request channel: an item (insert or flush) is taken on a clock edge with
//   start high and busy low; busy stays high while the item is worked on
// result channel: one beat per cycle with strobe high, taken at the end of
//   that cycle; the receiver cannot hold beats off
// insert: the region table is scanned one entry at a time through the
//   single port of the region memory (read, then compare and merge), and
//   an empty table goes straight to append; it gives no beat
// flush: one region is read per cycle and its beat follows in the next cycle;
//   busy is high while regions are read, beats come in back-to-back cycles,
//   the last marked is_last; an empty table gives one is_empty beat the
//   cycle after start and no busy
// results of a flush appear in the cycle after each memory read
// reset clears the region count, the overflow flag and the strobe; stored
//   regions are not cleared and are never read before written
module dirty_region_coalescer_core #(
  parameter int MAX_REGIONS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  drc_pkg::request_t request,
  output logic              strobe,
  output drc_pkg::result_t  result
);

  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);

  drc_pkg::ctrl_t ctrl;
  logic [AW-1:0]  addr;
  logic           touch;

  drc_control #(
    .MAX_REGIONS(MAX_REGIONS),
    .AW(AW),
    .CW(CW)
  ) u_control (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(request.cmd),
    .touch(touch),
    .busy(busy),
    .ctrl(ctrl),
    .addr(addr)
  );

  drc_datapath #(
    .MAX_REGIONS(MAX_REGIONS),
    .AW(AW)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .addr(addr),
    .request(request),
    .touch(touch),
    .strobe(strobe),
    .result(result)
  );

endmodule

/* sv/drc_checker.sv */
`include "assert_macros.svh"

module drc_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input drc_pkg::request_t request,
  input logic              strobe,
  input drc_pkg::result_t  result
);

  logic empty_zero;
  logic insert_beat;

  assign empty_zero = result.out_x == 16'sd0 && result.out_y == 16'sd0 &&
                      result.out_width == 16'd0 && result.out_height == 16'd0;
  assign insert_beat = start && !busy && request.cmd == drc_pkg::CMD_INSERT;

  `DRC_ASSERT_NOW(a_empty_beat, strobe && result.is_empty, result.is_last && empty_zero)
  `DRC_ASSERT_NOW(a_flush_busy, strobe && !result.is_last, busy && !result.is_empty)
  `DRC_ASSERT_NEXT(a_flush_burst, strobe && !result.is_last, strobe)
  `DRC_ASSERT_NEXT(a_insert_busy, insert_beat, busy && !strobe)
  `DRC_ASSERT_ALWAYS_NEXT(a_reset_quiet, rst, !strobe && !busy)

endmodule

bind dirty_region_coalescer_core drc_checker u_drc_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_REGIONS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SAT_LEN = 65535;

  typedef struct packed {
    bit                drain;
    drc_pkg::request_t req;
  } queued_req_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  drc_pkg::request_t request = '0;
  logic              busy;
  logic              strobe;
  drc_pkg::result_t  result;

  dirty_region_coalescer_core #(.MAX_REGIONS(MAX_REGIONS)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .strobe(strobe),
    .result(result)
  );

  always #6 clk = ~clk;

  // predicted region table
  drc_pkg::rect_t tracked[MAX_REGIONS];
  int    tracked_count = 0;
  bit    tracked_ovf = 1'b0;

  drc_pkg::result_t flush_beats_due[$];
  queued_req_t      queued[$];
  int               beats_predicted = 0;
  int               beats_checked = 0;
  int               errors = 0;
  int               idle_left = 0;
  bit               calm = 1'b0;
  int               cycles = 0;
  drc_pkg::result_t due;

  function automatic bit rects_touch(input drc_pkg::rect_t a, input int bx, by, bw, bh);
    int ax, ay, aw, ah;
    ax = $signed(a.x);
    ay = $signed(a.y);
    aw = a.w;
    ah = a.h;
    return !(ax + aw < bx || bx + bw < ax || ay + ah < by || by + bh < ay);
  endfunction

  function automatic void span_join(input int a0, alen, b0, blen,
                                    output logic [15:0] pos, len);
    int lo, hi, d;
    lo = (a0 < b0) ? a0 : b0;
    hi = (a0 + alen > b0 + blen) ? a0 + alen : b0 + blen;
    d = hi - lo;
    if (d > SAT_LEN) d = SAT_LEN;
    pos = lo[15:0];
    len = d[15:0];
  endfunction

  function automatic void table_apply(input drc_pkg::request_t r);
    int x, y, w, h, hit;
    drc_pkg::result_t beat;
    if (r.cmd == drc_pkg::CMD_FLUSH) begin
      if (tracked_count == 0) begin
        beat = '0;
        beat.is_last = 1'b1;
        beat.is_empty = 1'b1;
        beat.overflowed = tracked_ovf;
        flush_beats_due = {flush_beats_due, beat};
        beats_predicted++;
      end else begin
        for (int k = 0; k < tracked_count; k++) begin
          beat = '0;
          beat.out_x = tracked[k].x;
          beat.out_y = tracked[k].y;
          beat.out_width = tracked[k].w;
          beat.out_height = tracked[k].h;
          beat.is_last = (k == tracked_count - 1);
          beat.overflowed = tracked_ovf;
          flush_beats_due = {flush_beats_due, beat};
          beats_predicted++;
        end
      end
      tracked_count = 0;
      tracked_ovf = 1'b0;
    end else begin
      x = $signed(r.in_x);
      y = $signed(r.in_y);
      w = r.in_width;
      h = r.in_height;
      hit = -1;
      for (int k = 0; k < tracked_count; k++)
        if (hit < 0 && rects_touch(tracked[k], x, y, w, h)) hit = k;
      if (hit < 0 && tracked_count < MAX_REGIONS) begin
        tracked[tracked_count] = {r.in_x, r.in_y, r.in_width, r.in_height};
        tracked_count++;
      end else begin
        if (hit < 0) begin
          hit = MAX_REGIONS - 1;
          tracked_ovf = 1'b1;
        end
        span_join($signed(tracked[hit].x), tracked[hit].w, x, w,
                  tracked[hit].x, tracked[hit].w);
        span_join($signed(tracked[hit].y), tracked[hit].h, y, h,
                  tracked[hit].y, tracked[hit].h);
      end
    end
  endfunction

  task automatic push_item(input bit drain, input logic c, input int x, y, w, h);
    queued_req_t q;
    q.drain = drain;
    q.req.cmd = c;
    q.req.in_x = x[15:0];
    q.req.in_y = y[15:0];
    q.req.in_width = w[15:0];
    q.req.in_height = h[15:0];
    queued = {queued, q};
  endtask

  task automatic push_flush(input bit drain);
    push_item(drain, drc_pkg::CMD_FLUSH, $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535));
  endtask

  task automatic field_check(input string name, input logic [15:0] want, got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
    end else begin
      if (start && !busy) begin
        table_apply(request);
        void'(queued.pop_front());
        if ($urandom_range(0, 39) == 0) calm = !calm;
        if (calm) idle_left = 0;
        else
          case ($urandom_range(0, 99)) inside
            [0:39]:  idle_left = 0;
            [40:84]: idle_left = $urandom_range(1, 3);
            [85:96]: idle_left = $urandom_range(4, 12);
            default: idle_left = $urandom_range(20, 60);
          endcase
      end
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (queued.size() != 0 &&
                     !(queued[0].drain && beats_checked != beats_predicted)) begin
          start <= 1'b1;
          request <= queued[0].req;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (flush_beats_due.size() == 0) begin
        $display("%0t: beat with nothing due, expected none got %p", $time, result);
        errors++;
      end else begin
        due = flush_beats_due.pop_front();
        field_check("out_x", due.out_x, result.out_x);
        field_check("out_y", due.out_y, result.out_y);
        field_check("out_width", due.out_width, result.out_width);
        field_check("out_height", due.out_height, result.out_height);
        field_check("is_last", due.is_last, result.is_last);
        field_check("is_empty", due.is_empty, result.is_empty);
        field_check("overflowed", due.overflowed, result.overflowed);
        beats_checked <= beats_checked + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    int n, mode, m, x, y, w, h, random_items;

    // directed
    push_flush(1'b0);
    push_item(1'b0, drc_pkg::CMD_INSERT, -32768, -32768, 0, 0);
    push_item(1'b0, drc_pkg::CMD_INSERT, 32767, 32767, 65535, 65535);
    push_item(1'b0, drc_pkg::CMD_INSERT, 0, 0, 10, 10);
    push_item(1'b0, drc_pkg::CMD_INSERT, 10, 10, 5, 5);
    push_item(1'b0, drc_pkg::CMD_INSERT, 16, 0, 4, 4);
    push_flush(1'b0);
    push_item(1'b0, drc_pkg::CMD_INSERT, 32767, 100, 65535, 0);
    push_item(1'b0, drc_pkg::CMD_INSERT, -32768, 100, 65535, 0);
    push_flush(1'b0);
    for (int i = 0; i < MAX_REGIONS; i++)
      push_item(1'b0, drc_pkg::CMD_INSERT, i * 100, -500, 10, 10);
    push_item(1'b0, drc_pkg::CMD_INSERT, 5000, 5000, 3, 3);
    push_flush(1'b0);
    push_flush(1'b1);

    // random bursts of inserts, each closed by a flush
    random_items = 0;
    while (random_items < 340) begin
      n = $urandom_range(0, 24);
      if ($urandom_range(0, 3) == 0) n = $urandom_range(17, 30);
      mode = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        m = (mode == 3) ? $urandom_range(0, 2) : mode;
        case (m)
          0: begin
            x = $urandom_range(0, 128) - 64;
            y = $urandom_range(0, 128) - 64;
            w = $urandom_range(0, 40);
            h = $urandom_range(0, 40);
          end
          1: begin
            x = $urandom_range(0, 65535);
            y = $urandom_range(0, 65535);
            w = $urandom_range(0, 255);
            h = $urandom_range(0, 255);
          end
          default: begin
            x = $urandom_range(0, 65535);
            y = $urandom_range(0, 65535);
            w = $urandom_range(0, 65535);
            h = $urandom_range(0, 65535);
          end
        endcase
        if ($urandom_range(0, 19) == 0) w = $urandom_range(0, 1) ? 65535 : 0;
        if ($urandom_range(0, 19) == 0) h = $urandom_range(0, 1) ? 65535 : 0;
        push_item(i == 0 && $urandom_range(0, 9) == 0, drc_pkg::CMD_INSERT, x, y, w, h);
      end
      push_flush($urandom_range(0, 9) == 0);
      random_items += n + 1;
      if ($urandom_range(0, 7) == 0) begin
        push_flush(1'b0);
        random_items++;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (!(queued.size() == 0 && beats_checked == beats_predicted)) @(negedge clk);
    repeat (60) @(posedge clk);
    @(negedge clk);
    if (flush_beats_due.size() != 0) begin
      $display("%0t: %0d beats still due, expected 0 got %0d", $time,
               flush_beats_due.size(), flush_beats_due.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
